/* sv/unicycle_euler_propagate_defines.svh */
// Assertion macros for the unicycle Euler propagation block.
// Used by the checker module; needs clk and rst in scope.
`ifndef UNICYCLE_EULER_PROPAGATE_DEFINES_SVH
`define UNICYCLE_EULER_PROPAGATE_DEFINES_SVH

// same-cycle implication
`define UEP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uep check failed");

// next-cycle implication
`define UEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uep check failed");

`endif

/* sv/uep_pkg.sv */
// Shared types, constants and tables for the unicycle Euler propagation block.
// No dependencies.
`timescale 1ns / 1ps
package uep_pkg;

  localparam int MAX_STEPS    = 64;
  localparam int CORDIC_ITERS = 16;
  localparam int STEP_W       = $clog2(MAX_STEPS + 1);
  localparam int ITER_W       = $clog2(CORDIC_ITERS);

  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic [31:0]        TWO_PI_Q13  = 32'd51472;
  localparam logic signed [27:0] GAIN_Q24    = 28'sd10188014;
  localparam logic [16:0]        STEP_TIME_RESET = 17'd6554;
  localparam logic [16:0]        STEP_TIME_MAX   = 17'd65536;
  localparam logic [3:0]         WRAP_TOP_SHIFT  = 4'd14;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [15:0] start_heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
    logic [31:0]        duration;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [15:0] end_heading;
    logic               steps_truncated;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP_INIT,
    S_STEP,
    S_MUL_W,
    S_CORDIC_WAIT,
    S_MUL_C,
    S_MUL_S,
    S_ADD,
    S_WRAP_STEP,
    S_DONE
  } state_t;

  function automatic logic signed [19:0] atan_q16(input logic [4:0] idx);
    case (idx)
      5'd0:    atan_q16 = 20'sd51472;
      5'd1:    atan_q16 = 20'sd30386;
      5'd2:    atan_q16 = 20'sd16055;
      5'd3:    atan_q16 = 20'sd8150;
      5'd4:    atan_q16 = 20'sd4091;
      5'd5:    atan_q16 = 20'sd2047;
      5'd6:    atan_q16 = 20'sd1024;
      5'd7:    atan_q16 = 20'sd512;
      5'd8:    atan_q16 = 20'sd256;
      5'd9:    atan_q16 = 20'sd128;
      5'd10:   atan_q16 = 20'sd64;
      5'd11:   atan_q16 = 20'sd32;
      5'd12:   atan_q16 = 20'sd16;
      5'd13:   atan_q16 = 20'sd8;
      5'd14:   atan_q16 = 20'sd4;
      5'd15:   atan_q16 = 20'sd2;
      5'd16:   atan_q16 = 20'sd1;
      default: atan_q16 = 20'sd0;
    endcase
  endfunction

endpackage

/* sv/unicycle_euler_propagate.sv */
// Top level of the unicycle Euler propagation block: sequencer and pose registers.
// Depends on uep_pkg, uep_mul, uep_cordic and uep_wrap.
//
// One command runs at a time: busy rises at the cycle after start and falls after the
// one-cycle done strobe. Each Euler step runs the CORDIC, the yaw wrap and sequencing
// states around four passes through the single multiplier; a command runs at most 64
// steps. The result stays on result from the done cycle until the next start and the
// receiver cannot stall it.
`timescale 1ns / 1ps
module unicycle_euler_propagate (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  uep_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output uep_pkg::result_t result,
  input  logic             step_time_we,
  input  logic [16:0]      step_time_wdata
);
  import uep_pkg::*;

  state_t state, state_next;

  logic [16:0]        step_time;
  logic [16:0]        st;
  logic signed [31:0] x, y;
  logic signed [15:0] yaw;
  logic signed [31:0] v, w;
  logic [31:0]        rem;
  logic [STEP_W-1:0]  steps;
  logic               trunc;
  logic signed [32:0] travel;
  logic signed [30:0] dyaw;
  logic [31:0]        dx;
  logic [31:0]        dt;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic signed [50:0] rnd16, rnd14, rnd19;

  logic               cordic_go, cordic_done;
  logic signed [15:0] cos_q14, sin_q14;
  logic               wrap_go, wrap_done;
  logic signed [31:0] wrap_val;
  logic signed [15:0] wrapped;
  logic [16:0]        st_clip;

  uep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  uep_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .go      (cordic_go),
    .yaw     (yaw),
    .done    (cordic_done),
    .cos_q14 (cos_q14),
    .sin_q14 (sin_q14)
  );

  uep_wrap u_wrap (
    .clk     (clk),
    .rst     (rst),
    .go      (wrap_go),
    .val     (wrap_val),
    .done    (wrap_done),
    .wrapped (wrapped)
  );

  always_comb begin
    dt = (rem < 32'(st)) ? rem : 32'(st);
    st_clip = (step_time == 17'd0) ? 17'd1 :
              (step_time > STEP_TIME_MAX) ? STEP_TIME_MAX : step_time;
    rnd16 = (prod + (51'sd1 <<< 15)) >>> 16;
    rnd14 = (prod + (51'sd1 <<< 13)) >>> 14;
    rnd19 = (prod + (51'sd1 <<< 18)) >>> 19;
    mul_a = {w[31], w};
    mul_b = {1'b0, dt[16:0]};
    case (state)
      S_STEP:  mul_a = {v[31], v};
      S_MUL_C: begin
        mul_a = travel;
        mul_b = 18'(cos_q14);
      end
      S_MUL_S: begin
        mul_a = travel;
        mul_b = 18'(sin_q14);
      end
      default: ;
    endcase
    wrap_val = 32'(yaw) + 32'(dyaw);
    if (state == S_IDLE) wrap_val = 32'(cmd.start_heading);
  end

  always_comb begin
    state_next = state;
    cordic_go = 1'b0;
    wrap_go = 1'b0;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          wrap_go = 1'b1;
          state_next = S_WRAP_INIT;
        end
      end
      S_WRAP_INIT: if (wrap_done) state_next = S_STEP;
      S_STEP: begin
        cordic_go = 1'b1;
        state_next = S_MUL_W;
      end
      S_MUL_W:       state_next = S_CORDIC_WAIT;
      S_CORDIC_WAIT: if (cordic_done) state_next = S_MUL_C;
      S_MUL_C:       state_next = S_MUL_S;
      S_MUL_S:       state_next = S_ADD;
      S_ADD: begin
        wrap_go = 1'b1;
        state_next = S_WRAP_STEP;
      end
      S_WRAP_STEP: begin
        if (wrap_done) begin
          if (rem < 32'(st) || steps >= STEP_W'(MAX_STEPS)) state_next = S_DONE;
          else state_next = S_STEP;
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_time <= STEP_TIME_RESET;
    end else begin
      state <= state_next;
      if (step_time_we) step_time <= step_time_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          x <= cmd.start_x;
          y <= cmd.start_y;
          v <= cmd.speed;
          w <= cmd.turn_rate;
          rem <= cmd.duration;
          st <= st_clip;
          steps <= '0;
          trunc <= 1'b0;
        end
      end
      S_WRAP_INIT: if (wrap_done) yaw <= wrapped;
      S_MUL_W:       travel <= 33'(rnd16);
      S_CORDIC_WAIT: dyaw <= 31'(rnd19);
      S_MUL_S:       dx <= 32'(rnd14);
      S_ADD: begin
        x <= x + dx;
        y <= y + 32'(rnd14);
        rem <= rem - dt;
        steps <= steps + 1'b1;
      end
      S_WRAP_STEP: begin
        if (wrap_done) begin
          yaw <= wrapped;
          if (rem >= 32'(st) && steps >= STEP_W'(MAX_STEPS)) trunc <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    result.end_x = x;
    result.end_y = y;
    result.end_heading = yaw;
    result.steps_truncated = trunc;
  end

endmodule

/* sv/uep_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on uep_pkg.
`timescale 1ns / 1ps
module uep_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [17:0] b,
  output logic signed [50:0] p
);
  import uep_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* sv/uep_cordic.sv */
// Iterative rotation-mode CORDIC giving cos and sin in Q2.14 from a Q3.13 yaw.
// Depends on uep_pkg.
`timescale 1ns / 1ps
module uep_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [15:0] yaw,
  output logic               done,
  output logic signed [15:0] cos_q14,
  output logic signed [15:0] sin_q14
);
  import uep_pkg::*;

  logic signed [27:0] vx, vy;
  logic signed [19:0] z;
  logic               flip;
  logic               running;
  logic [ITER_W-1:0]  iter;
  logic signed [15:0] a_pre;
  logic               flip_pre;
  logic signed [27:0] sx, sy;
  logic signed [19:0] ang;
  logic signed [27:0] rx, ry;
  logic signed [15:0] cx, cy;

  always_comb begin
    a_pre = yaw;
    flip_pre = 1'b0;
    if (yaw > HALF_PI_Q13) begin
      a_pre = yaw - PI_Q13;
      flip_pre = 1'b1;
    end else if (yaw < -HALF_PI_Q13) begin
      a_pre = yaw + PI_Q13;
      flip_pre = 1'b1;
    end
    sx = vx >>> iter;
    sy = vy >>> iter;
    ang = atan_q16(5'(iter));
    rx = (vx + 28'sd512) >>> 10;
    ry = (vy + 28'sd512) >>> 10;
    if (rx > 28'sd16384) cx = 16'sd16384;
    else if (rx < -28'sd16384) cx = -16'sd16384;
    else cx = 16'(rx);
    if (ry > 28'sd16384) cy = 16'sd16384;
    else if (ry < -28'sd16384) cy = -16'sd16384;
    else cy = 16'(ry);
    cos_q14 = flip ? -cx : cx;
    sin_q14 = flip ? -cy : cy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        iter <= '0;
        vx <= GAIN_Q24;
        vy <= '0;
        z <= 20'(a_pre) <<< 3;
        flip <= flip_pre;
      end else if (running) begin
        if (z >= 0) begin
          vx <= vx - sy;
          vy <= vy + sx;
          z <= z - ang;
        end else begin
          vx <= vx + sy;
          vy <= vy - sx;
          z <= z + ang;
        end
        if (iter == ITER_W'(CORDIC_ITERS - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

endmodule

/* sv/uep_wrap.sv */
// Iterative yaw wrap to [-pi, pi) in Q3.13 by shift-and-subtract reduction.
// Depends on uep_pkg.
`timescale 1ns / 1ps
module uep_wrap (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [31:0] val,
  output logic               done,
  output logic signed [15:0] wrapped
);
  import uep_pkg::*;

  logic [31:0] mag;
  logic        neg;
  logic        running;
  logic [3:0]  shift;
  logic signed [31:0] t;
  logic [31:0] lim;
  logic [31:0] r;

  always_comb begin
    t = val + 32'(PI_Q13);
    lim = TWO_PI_Q13 << shift;
    r = (neg && mag != 32'd0) ? TWO_PI_Q13 - mag : mag;
    wrapped = 16'(r) - PI_Q13;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      shift <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        mag <= t[31] ? 32'(-t) : 32'(t);
        neg <= t[31];
        shift <= WRAP_TOP_SHIFT;
      end else if (running) begin
        if (mag >= lim) mag <= mag - lim;
        if (shift == 4'd0) begin
          running <= 1'b0;
          done <= 1'b1;
        end else begin
          shift <= shift - 1'b1;
        end
      end
    end
  end

endmodule

/* sv/uep_checker.sv */
// Port-level checker for the unicycle Euler propagation block, bound to the top level.
// Depends on unicycle_euler_propagate_defines.svh.
`timescale 1ns / 1ps
`include "unicycle_euler_propagate_defines.svh"
module uep_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `UEP_ASSERT_NOW(a_done_busy, done, busy)
  `UEP_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `UEP_ASSERT_NEXT(a_done_idle, done, !busy)
  `UEP_ASSERT_NEXT(a_start_no_done, start && !busy, !done)

endmodule

bind unicycle_euler_propagate uep_checker u_uep_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
